@@ sv/lip_pkg.sv @@
// Shared constants and types of the line intersection point block.
package lip_pkg;

    localparam int OUT_W = 24;
    localparam longint OUT_MAX = 64'sd8388607;
    localparam longint OUT_MIN = -64'sd8388608;
    // Quotients above this magnitude are clamped without adding the start point.
    localparam longint Q_LIMIT = 64'sd1099511627776;
    localparam int Q_DEPTH = 4;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

@@ sv/lip_if.sv @@
// Request and result channel interfaces of the line intersection point block.
interface lip_seg_if #(
    parameter int COORD_BITS = 12
) ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] over_start_x;
    logic [COORD_BITS-1:0] over_start_y;
    logic [COORD_BITS-1:0] over_end_x;
    logic [COORD_BITS-1:0] over_end_y;
    logic [COORD_BITS-1:0] under_start_x;
    logic [COORD_BITS-1:0] under_start_y;
    logic [COORD_BITS-1:0] under_end_x;
    logic [COORD_BITS-1:0] under_end_y;

    modport source (
        output valid, over_start_x, over_start_y, over_end_x, over_end_y,
               under_start_x, under_start_y, under_end_x, under_end_y,
        input  ready
    );
    modport sink (
        input  valid, over_start_x, over_start_y, over_end_x, over_end_y,
               under_start_x, under_start_y, under_end_x, under_end_y,
        output ready
    );
endinterface

interface lip_res_if import lip_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] cross_x;
    logic signed [OUT_W-1:0] cross_y;
    logic                    parallel;
    logic                    saturated;

    modport source (
        output valid, cross_x, cross_y, parallel, saturated,
        input  ready
    );
    modport sink (
        input  valid, cross_x, cross_y, parallel, saturated,
        output ready
    );
endinterface

@@ sv/line_intersection_point.sv @@
// Top level of the line intersection point block.
//
// Each request carries the end points of an over segment and an under segment in unsigned
// pixel coordinates. The result is the crossing point of the two infinite lines, given as
// over_start + over_delta * d1 / d0 in signed fixed point with FRAC_BITS fraction bits,
// the quotient truncated toward zero and the sum clamped to 24 bits (saturated flags a
// clamp). Parallel lines give zero coordinates with parallel set. The block takes one
// request per clock while nothing stalls and returns one result per request, in order.
// A request passes three front stages for differences, cross products and the determinant,
// one queue slot, back stages for magnitudes, the product and the scaled numerator, one
// restoring-division stage per quotient bit (3*COORD_BITS + 1 + FRAC_BITS of them) and
// the result register. The queue between front and back holds four requests so each half
// stalls on its own.
module line_intersection_point import lip_pkg::*; #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lip_seg_if.sink   i_seg,
    lip_res_if.source o_res
);
    localparam int EW = 8 * COORD_BITS + 7;

    logic          push, pop;
    logic [EW-1:0] entry_in, entry_out;
    t_q_stat       qstat;

    // Classify each request: determinant, numerator and the parallel flag.
    lip_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_seg.valid),
        .o_ready (i_seg.ready),
        .i_ox0   (i_seg.over_start_x),
        .i_oy0   (i_seg.over_start_y),
        .i_ox1   (i_seg.over_end_x),
        .i_oy1   (i_seg.over_end_y),
        .i_ux0   (i_seg.under_start_x),
        .i_uy0   (i_seg.under_start_y),
        .i_ux1   (i_seg.under_end_x),
        .i_uy1   (i_seg.under_end_y),
        .i_qstat (qstat),
        .o_push  (push),
        .o_entry (entry_in)
    );

    // Hold classified requests until the back end can take them.
    lip_queue #(
        .WIDTH(EW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (entry_in),
        .i_pop   (pop),
        .o_data  (entry_out),
        .o_stat  (qstat)
    );

    // Divide, add the start point, clamp and present the result.
    lip_back #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_qstat     (qstat),
        .i_entry     (entry_out),
        .o_pop       (pop),
        .o_valid     (o_res.valid),
        .i_ready     (o_res.ready),
        .o_cross_x   (o_res.cross_x),
        .o_cross_y   (o_res.cross_y),
        .o_parallel  (o_res.parallel),
        .o_saturated (o_res.saturated)
    );
endmodule

@@ sv/lip_front.sv @@
// Front end: differences, cross products, determinant and parallel check.
module lip_front import lip_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [COORD_BITS-1:0] i_ox0,
    input  logic [COORD_BITS-1:0] i_oy0,
    input  logic [COORD_BITS-1:0] i_ox1,
    input  logic [COORD_BITS-1:0] i_oy1,
    input  logic [COORD_BITS-1:0] i_ux0,
    input  logic [COORD_BITS-1:0] i_uy0,
    input  logic [COORD_BITS-1:0] i_ux1,
    input  logic [COORD_BITS-1:0] i_uy1,
    input  t_q_stat               i_qstat,
    output logic                  o_push,
    output logic [8*COORD_BITS+6:0] o_entry
);
    localparam int C  = COORD_BITS;
    localparam int PW = 2 * C + 2;

    logic r_v1, r_v2, r_v3;
    logic adv;

    logic        [C-1:0] r1_ox, r1_oy;
    logic signed [C:0]   r1_dox, r1_doy, r1_dux, r1_duy, r1_ex, r1_ey;

    logic        [C-1:0]  r2_ox, r2_oy;
    logic signed [C:0]    r2_dox, r2_doy;
    logic signed [PW-1:0] r2_p0, r2_p1, r2_p2, r2_p3;

    logic        [C-1:0]  r3_ox, r3_oy;
    logic signed [C:0]    r3_dox, r3_doy;
    logic signed [PW-1:0] r3_d0, r3_d1;

    // Advance the whole front unless its last stage waits on a full queue.
    assign adv     = !r_v3 || !i_qstat.full;
    assign o_ready = adv;
    assign o_push  = r_v3 && !i_qstat.full;
    assign o_entry = {r3_ox, r3_oy, r3_dox, r3_doy, r3_d0, r3_d1, (r3_d0 == '0)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_ox  <= i_ox0;
            r1_oy  <= i_oy0;
            r1_dox <= $signed({1'b0, i_ox1}) - $signed({1'b0, i_ox0});
            r1_doy <= $signed({1'b0, i_oy1}) - $signed({1'b0, i_oy0});
            r1_dux <= $signed({1'b0, i_ux0}) - $signed({1'b0, i_ux1});
            r1_duy <= $signed({1'b0, i_uy0}) - $signed({1'b0, i_uy1});
            r1_ex  <= $signed({1'b0, i_ux0}) - $signed({1'b0, i_ox0});
            r1_ey  <= $signed({1'b0, i_uy0}) - $signed({1'b0, i_oy0});

            r2_ox  <= r1_ox;
            r2_oy  <= r1_oy;
            r2_dox <= r1_dox;
            r2_doy <= r1_doy;
            r2_p0  <= PW'(r1_dox) * PW'(r1_duy);
            r2_p1  <= PW'(r1_doy) * PW'(r1_dux);
            r2_p2  <= PW'(r1_ex) * PW'(r1_duy);
            r2_p3  <= PW'(r1_ey) * PW'(r1_dux);

            r3_ox  <= r2_ox;
            r3_oy  <= r2_oy;
            r3_dox <= r2_dox;
            r3_doy <= r2_doy;
            r3_d0  <= r2_p0 - r2_p1;
            r3_d1  <= r2_p2 - r2_p3;
        end
    end
endmodule

@@ sv/lip_queue.sv @@
// Small request queue between the front end and the back end.
module lip_queue import lip_pkg::*; #(
    parameter int WIDTH = 103
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_q_stat          o_stat
);
    localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [0:Q_DEPTH-1];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_stat.full  = (r_count == CW'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr <= (r_wr == AW'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule

@@ sv/lip_back.sv @@
// Back end: magnitudes, scaled products, pipelined division, saturation, result register.
module lip_back import lip_pkg::*; #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_q_stat                 i_qstat,
    input  logic [8*COORD_BITS+6:0] i_entry,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [OUT_W-1:0] o_cross_x,
    output logic signed [OUT_W-1:0] o_cross_y,
    output logic                    o_parallel,
    output logic                    o_saturated
);
    localparam int C  = COORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * C + 2;
    localparam int DW = 2 * C + 1;
    localparam int MW = 3 * C + 1;
    localparam int NW = MW + F;
    localparam int SW = ((NW > C + F) ? NW : C + F) + 2;
    localparam int QX = (NW > 41) ? NW : 42;

    typedef struct packed {
        logic [C-1:0]  ox;
        logic [C-1:0]  oy;
        logic          negx;
        logic          negy;
        logic          par;
        logic [DW-1:0] den;
        logic [DW-1:0] remx;
        logic [DW-1:0] remy;
        logic [NW-1:0] nqx;
        logic [NW-1:0] nqy;
    } t_dv;

    function automatic logic [DW+NW-1:0] div_step(input logic [DW-1:0] rem,
                                                  input logic [NW-1:0] nq,
                                                  input logic [DW-1:0] den);
        logic [DW:0] t;
        logic [DW:0] d;
        logic [DW:0] diff;
        t    = {rem, nq[NW-1]};
        d    = {1'b0, den};
        diff = t - d;
        if (t >= d) begin
            return {diff[DW-1:0], nq[NW-2:0], 1'b1};
        end
        return {t[DW-1:0], nq[NW-2:0], 1'b0};
    endfunction

    // Returns {saturated, coordinate}.
    function automatic logic [OUT_W:0] coord_out(input logic [C-1:0] base,
                                                 input logic [NW-1:0] q,
                                                 input logic neg);
        logic [QX-1:0]      qe;
        logic signed [SW-1:0] b;
        logic signed [SW-1:0] qq;
        logic signed [SW-1:0] v;
        qe = QX'(q);
        b  = SW'(base) << F;
        qq = SW'(q);
        v  = neg ? b - qq : b + qq;
        if (qe > QX'(Q_LIMIT)) begin
            return neg ? {1'b1, OUT_W'(OUT_MIN)} : {1'b1, OUT_W'(OUT_MAX)};
        end
        if (v > OUT_MAX) begin
            return {1'b1, OUT_W'(OUT_MAX)};
        end
        if (v < OUT_MIN) begin
            return {1'b1, OUT_W'(OUT_MIN)};
        end
        return {1'b0, v[OUT_W-1:0]};
    endfunction

    logic        [C-1:0]  e_ox, e_oy;
    logic signed [C:0]    e_dox, e_doy;
    logic signed [PW-1:0] e_d0, e_d1;
    logic                 e_par;
    logic        [C:0]    ax_w, ay_w;
    logic        [PW-1:0] a1_w, a0_w;

    logic adv;
    logic r_v0, r_v1, r_ov;
    logic r_dvv [0:NW];
    t_dv  r_dv  [0:NW];

    logic [C-1:0]  r0_ox, r0_oy, r0_ax, r0_ay;
    logic [DW-1:0] r0_a1, r0_den;
    logic          r0_negx, r0_negy, r0_par;

    logic [C-1:0]  r1_ox, r1_oy;
    logic [MW-1:0] r1_mx, r1_my;
    logic [DW-1:0] r1_den;
    logic          r1_negx, r1_negy, r1_par;

    logic signed [OUT_W-1:0] r_cx, r_cy;
    logic                    r_par, r_sat;
    logic [OUT_W:0]          res_x, res_y;

    assign {e_ox, e_oy, e_dox, e_doy, e_d0, e_d1, e_par} = i_entry;
    assign ax_w = e_dox[C]    ? (~e_dox + 1'b1) : e_dox;
    assign ay_w = e_doy[C]    ? (~e_doy + 1'b1) : e_doy;
    assign a1_w = e_d1[PW-1]  ? (~e_d1 + 1'b1)  : e_d1;
    assign a0_w = e_d0[PW-1]  ? (~e_d0 + 1'b1)  : e_d0;

    // Advance every stage unless the finished result is still waiting.
    assign adv   = !r_ov || i_ready;
    assign o_pop = adv && !i_qstat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_v0 <= !i_qstat.empty;
            r_v1 <= r_v0;
            r_ov <= r_dvv[NW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r0_ox   <= e_ox;
            r0_oy   <= e_oy;
            r0_ax   <= ax_w[C-1:0];
            r0_ay   <= ay_w[C-1:0];
            r0_a1   <= a1_w[DW-1:0];
            r0_den  <= a0_w[DW-1:0];
            r0_negx <= e_dox[C] ^ e_d1[PW-1] ^ e_d0[PW-1];
            r0_negy <= e_doy[C] ^ e_d1[PW-1] ^ e_d0[PW-1];
            r0_par  <= e_par;

            r1_ox   <= r0_ox;
            r1_oy   <= r0_oy;
            r1_mx   <= MW'(r0_ax) * MW'(r0_a1);
            r1_my   <= MW'(r0_ay) * MW'(r0_a1);
            r1_den  <= r0_den;
            r1_negx <= r0_negx;
            r1_negy <= r0_negy;
            r1_par  <= r0_par;

            r_dv[0].ox   <= r1_ox;
            r_dv[0].oy   <= r1_oy;
            r_dv[0].negx <= r1_negx;
            r_dv[0].negy <= r1_negy;
            r_dv[0].par  <= r1_par;
            r_dv[0].den  <= r1_den;
            r_dv[0].remx <= '0;
            r_dv[0].remy <= '0;
            r_dv[0].nqx  <= NW'(r1_mx) << F;
            r_dv[0].nqy  <= NW'(r1_my) << F;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvv[0] <= 1'b0;
        end else if (adv) begin
            r_dvv[0] <= r_v1;
        end
    end

    // One quotient bit per stage for both coordinates.
    for (genvar s = 0; s < NW; s++) begin : g_div
        logic [DW+NW-1:0] stx, sty;
        assign stx = div_step(r_dv[s].remx, r_dv[s].nqx, r_dv[s].den);
        assign sty = div_step(r_dv[s].remy, r_dv[s].nqy, r_dv[s].den);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dvv[s+1] <= 1'b0;
            end else if (adv) begin
                r_dvv[s+1] <= r_dvv[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dv[s+1].ox   <= r_dv[s].ox;
                r_dv[s+1].oy   <= r_dv[s].oy;
                r_dv[s+1].negx <= r_dv[s].negx;
                r_dv[s+1].negy <= r_dv[s].negy;
                r_dv[s+1].par  <= r_dv[s].par;
                r_dv[s+1].den  <= r_dv[s].den;
                {r_dv[s+1].remx, r_dv[s+1].nqx} <= stx;
                {r_dv[s+1].remy, r_dv[s+1].nqy} <= sty;
            end
        end
    end

    assign res_x = coord_out(r_dv[NW].ox, r_dv[NW].nqx, r_dv[NW].negx);
    assign res_y = coord_out(r_dv[NW].oy, r_dv[NW].nqy, r_dv[NW].negy);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_dv[NW].par) begin
                r_cx  <= '0;
                r_cy  <= '0;
                r_par <= 1'b1;
                r_sat <= 1'b0;
            end else begin
                r_cx  <= res_x[OUT_W-1:0];
                r_cy  <= res_y[OUT_W-1:0];
                r_par <= 1'b0;
                r_sat <= res_x[OUT_W] | res_y[OUT_W];
            end
        end
    end

    assign o_valid     = r_ov;
    assign o_cross_x   = r_cx;
    assign o_cross_y   = r_cy;
    assign o_parallel  = r_par;
    assign o_saturated = r_sat;
endmodule

@@ tb/line_intersection_point_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for line_intersection_point: corner and random segment pairs, in-order checks.
module line_intersection_point_test;
    import lip_pkg::*;

    localparam int COORD       = 12;
    localparam int CMAX        = (1 << COORD) - 1;
    localparam int FRAC        = 8;
    // Extra wait after the drain, a margin on top of the unstalled latency.
    localparam int TAIL_CYCLES = 3 * COORD + FRAC + 8 + 40;
    // Long enough to fill the front stages, the queue and the divider chain several times.
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 240;

    // One request: both end points of the over and the under segment.
    typedef struct packed {
        bit [COORD-1:0] osx;
        bit [COORD-1:0] osy;
        bit [COORD-1:0] oex;
        bit [COORD-1:0] oey;
        bit [COORD-1:0] usx;
        bit [COORD-1:0] usy;
        bit [COORD-1:0] uex;
        bit [COORD-1:0] uey;
    } seg_t;

    // One result as it leaves the block.
    typedef struct packed {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic                    parallel;
        logic                    saturated;
    } crossing_t;

    // Holds the crossings still owed by the block, oldest first, and grades each result.
    class crossing_scoreboard;
        crossing_t crossings_due[$];
        int        mismatches;

        // start + delta * d1 / d0 in fixed point, quotient truncated toward zero, then clamped.
        static function longint scaled_coord(longint start, longint delta, longint d1,
                                             longint d0, inout bit clamped);
            bit     neg;
            longint md, m1, m0, q, v;
            neg = ((delta < 0) != (d1 < 0)) != (d0 < 0);
            md  = (delta < 0) ? -delta : delta;
            m1  = (d1 < 0) ? -d1 : d1;
            m0  = (d0 < 0) ? -d0 : d0;
            // Magnitudes stay below 2^46 here, so plain 64-bit math is exact.
            q = ((md * m1) <<< FRAC) / m0;
            if (q > Q_LIMIT) begin
                v = neg ? OUT_MIN - 1 : OUT_MAX + 1;
            end else begin
                v = neg ? (start <<< FRAC) - q : (start <<< FRAC) + q;
            end
            if (v > OUT_MAX) begin
                v       = OUT_MAX;
                clamped = 1'b1;
            end else if (v < OUT_MIN) begin
                v       = OUT_MIN;
                clamped = 1'b1;
            end
            return v;
        endfunction

        // Crossing of the two infinite lines by Cramer's rule.
        static function crossing_t crossing_of(seg_t s);
            longint    ox0, oy0, ox1, oy1, ux0, uy0, ux1, uy1;
            longint    dox, doy, dux, duy, d0, d1, cx, cy;
            bit        clamped;
            crossing_t r;
            ox0 = longint'(s.osx);
            oy0 = longint'(s.osy);
            ox1 = longint'(s.oex);
            oy1 = longint'(s.oey);
            ux0 = longint'(s.usx);
            uy0 = longint'(s.usy);
            ux1 = longint'(s.uex);
            uy1 = longint'(s.uey);
            dox = ox1 - ox0;
            doy = oy1 - oy0;
            dux = ux0 - ux1;
            duy = uy0 - uy1;
            d0  = dox * duy - doy * dux;
            d1  = (ux0 - ox0) * duy - (uy0 - oy0) * dux;
            r   = '0;
            if (d0 == 0) begin
                // Parallel or degenerate: zero point, flag set, no clamp.
                r.parallel = 1'b1;
                return r;
            end
            clamped     = 1'b0;
            cx          = scaled_coord(ox0, dox, d1, d0, clamped);
            cy          = scaled_coord(oy0, doy, d1, d0, clamped);
            r.x         = cx[OUT_W-1:0];
            r.y         = cy[OUT_W-1:0];
            r.saturated = clamped;
            return r;
        endfunction

        function void note_request(seg_t s);
            crossings_due.push_back(crossing_of(s));
        endfunction

        function void check_result(crossing_t got);
            crossing_t want;
            if (crossings_due.size() == 0) begin
                $error("result with no request outstanding: cross_x %0d cross_y %0d",
                       got.x, got.y);
                mismatches++;
                return;
            end
            want = crossings_due.pop_front();
            if (got.x !== want.x) begin
                $error("cross_x: expected %0d, actual %0d", want.x, got.x);
                mismatches++;
            end
            if (got.y !== want.y) begin
                $error("cross_y: expected %0d, actual %0d", want.y, got.y);
                mismatches++;
            end
            if (got.parallel !== want.parallel) begin
                $error("parallel: expected %0b, actual %0b", want.parallel, got.parallel);
                mismatches++;
            end
            if (got.saturated !== want.saturated) begin
                $error("saturated: expected %0b, actual %0b", want.saturated, got.saturated);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    lip_seg_if #(.COORD_BITS(COORD)) seg ();
    lip_res_if                       res ();

    crossing_scoreboard board;
    int send_pct      = 0;      // chance in percent that the sender idles a cycle
    int recv_pct      = 0;      // chance in percent that the receiver stalls a cycle
    int requests_sent = 0;
    int hold_at       = -1;     // request count at which the long receiver hold-off starts

    always #6 i_clk = ~i_clk;

    line_intersection_point #(
        .COORD_BITS(COORD),
        .FRAC_BITS (FRAC)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_seg  (seg),
        .o_res  (res)
    );

    // Build a request from eight coordinates, over segment first.
    function automatic seg_t pair(int osx, int osy, int oex, int oey,
                                  int usx, int usy, int uex, int uey);
        seg_t s;
        s.osx = COORD'(osx);
        s.osy = COORD'(osy);
        s.oex = COORD'(oex);
        s.oey = COORD'(oey);
        s.usx = COORD'(usx);
        s.usy = COORD'(usy);
        s.uex = COORD'(uex);
        s.uey = COORD'(uey);
        return s;
    endfunction

    // Offer one request, idling first at the sender's rate, and hold it until it is taken.
    task automatic offer(input seg_t s);
        while ($urandom_range(99) < send_pct) begin
            seg.valid <= 1'b0;
            @(posedge i_clk);
        end
        seg.valid         <= 1'b1;
        seg.over_start_x  <= s.osx;
        seg.over_start_y  <= s.osy;
        seg.over_end_x    <= s.oex;
        seg.over_end_y    <= s.oey;
        seg.under_start_x <= s.usx;
        seg.under_start_y <= s.usy;
        seg.under_end_x   <= s.uex;
        seg.under_end_y   <= s.uey;
        do @(posedge i_clk); while (!seg.ready);
        board.note_request(s);
        requests_sent++;
    endtask

    // Drop valid and wait until every owed crossing has come back.
    task automatic wait_drained();
        seg.valid <= 1'b0;
        while (board.crossings_due.size() != 0) @(posedge i_clk);
    endtask

    // Random requests. Most are shaped so the interesting paths get hit often: parallel
    // and near-parallel pairs (clamps and huge quotients), a determinant of magnitude one,
    // tight windows (many fractions and degenerate segments) and corner values.
    task automatic run_phase(input int count);
        seg_t s;
        int   kind, lo, hi, tx, ty, bump, m;
        int   ox0, oy0, ox1, oy1, ux0, uy0, ux1, uy1;
        bit   built;
        for (int n = 0; n < count; n++) begin
            kind  = $urandom_range(99);
            s     = seg_t'({$urandom(), $urandom(), $urandom()});
            built = 1'b0;
            if (kind < 30) begin
                // Keep the uniform pair as drawn.
            end else if (kind < 50) begin
                lo = $urandom_range(CMAX - 15);
                for (int f = 0; f < 8; f++) begin
                    s[f*COORD +: COORD] = COORD'(lo + $urandom_range(15));
                end
            end else if (kind < 85) begin
                // Translate the over segment to form the under one, then nudge for near-parallel.
                ox0 = int'(s.osx);
                oy0 = int'(s.osy);
                ox1 = int'(s.oex);
                oy1 = int'(s.oey);
                lo  = -((ox0 < ox1) ? ox0 : ox1);
                hi  = CMAX - ((ox0 > ox1) ? ox0 : ox1);
                tx  = lo + $urandom_range(hi - lo);
                lo  = -((oy0 < oy1) ? oy0 : oy1);
                hi  = CMAX - ((oy0 > oy1) ? oy0 : oy1);
                ty  = lo + $urandom_range(hi - lo);
                ux0 = ox0 + tx;
                ux1 = ox1 + tx;
                uy0 = oy0 + ty;
                uy1 = oy1 + ty;
                if (kind >= 65) begin
                    bump = $urandom_range(1, 3) * ($urandom_range(1) ? 1 : -1);
                    if ($urandom_range(1)) begin
                        ux1 = ux1 + bump;
                        ux1 = (ux1 < 0) ? 0 : (ux1 > CMAX) ? CMAX : ux1;
                    end else begin
                        uy1 = uy1 + bump;
                        uy1 = (uy1 < 0) ? 0 : (uy1 > CMAX) ? CMAX : uy1;
                    end
                end
                built = 1'b1;
            end else if (kind < 93) begin
                // Directions (2m+1, m+1) and (2m-1, m) give a determinant of magnitude one.
                m     = $urandom_range(1, (CMAX - 1) / 2);
                ox0   = $urandom_range(CMAX - 2 * m - 1);
                oy0   = $urandom_range(CMAX - m - 1);
                ox1   = ox0 + 2 * m + 1;
                oy1   = oy0 + m + 1;
                ux0   = $urandom_range(CMAX - 2 * m + 1);
                uy0   = $urandom_range(CMAX - m);
                ux1   = ux0 + 2 * m - 1;
                uy1   = uy0 + m;
                built = 1'b1;
            end else begin
                for (int f = 0; f < 8; f++) begin
                    case ($urandom_range(4))
                        0: s[f*COORD +: COORD] = '0;
                        1: s[f*COORD +: COORD] = COORD'(1);
                        2: s[f*COORD +: COORD] = COORD'(CMAX - 1);
                        3: s[f*COORD +: COORD] = COORD'(CMAX);
                        default: ;
                    endcase
                end
            end
            if (built) begin
                // Flip the under segment's direction half the time.
                if ($urandom_range(1)) begin
                    tx  = ux0;
                    ux0 = ux1;
                    ux1 = tx;
                    ty  = uy0;
                    uy0 = uy1;
                    uy1 = ty;
                end
                s = pair(ox0, oy0, ox1, oy1, ux0, uy0, ux1, uy1);
            end
            offer(s);
        end
    endtask

    // Stimulus: directed corners first, then four random phases with different idling.
    initial begin : request_side
        board             = new();
        seg.valid         = 1'b0;
        seg.over_start_x  = '0;
        seg.over_start_y  = '0;
        seg.over_end_x    = '0;
        seg.over_end_y    = '0;
        seg.under_start_x = '0;
        seg.under_start_y = '0;
        seg.under_end_x   = '0;
        seg.under_end_y   = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // All zero and all max: both segments collapse to points, so the lines are parallel.
        offer(pair(0, 0, 0, 0, 0, 0, 0, 0));
        offer(pair(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
        // Full diagonals: crossing on a half pixel, both directions.
        offer(pair(0, 0, CMAX, CMAX, 0, CMAX, CMAX, 0));
        offer(pair(CMAX, 0, 0, CMAX, 0, 0, CMAX, CMAX));
        // Vertical over horizontal, exact integer crossing.
        offer(pair(100, 0, 100, CMAX, 0, 200, CMAX, 200));
        // Parallel distinct lines, collinear lines, and each segment as a single point.
        offer(pair(0, 0, 100, 50, 10, 0, 110, 50));
        offer(pair(0, 0, 10, 10, 20, 20, 30, 30));
        offer(pair(5, 5, 5, 5, 0, 0, 10, 3));
        offer(pair(0, 0, 10, 3, 7, 7, 7, 7));
        // Near-parallel: x clamps high, then the mirrored pair clamps low.
        offer(pair(0, 0, CMAX, 1, 0, CMAX, CMAX, CMAX - 1));
        offer(pair(CMAX, CMAX, 0, CMAX - 1, CMAX, 0, 0, 1));
        // Determinant of minus one with a wide gap: quotient beyond the clamp limit.
        offer(pair(0, 0, CMAX, 2048, 0, 2000, 4093, 4047));
        // Determinant of one over a short gap: large but under the limit.
        offer(pair(0, 0, CMAX, CMAX - 1, 0, 2, CMAX - 1, CMAX));
        // Fractional crossings, some on the extended lines with negative coordinates,
        // to exercise truncation toward zero on both signs.
        offer(pair(1, 2, 4, 7, 0, 5, 6, 1));
        offer(pair(3, 1, 0, 2, 2, 0, 1, 5));
        offer(pair(10, 10, 20, 11, 30, 0, 31, 5));
        offer(pair(4000, 4000, CMAX, 4090, 0, 0, 1, 3));
        offer(pair(CMAX, 0, CMAX - 3, 1, 0, CMAX, 7, CMAX - 2));
        offer(pair(1, 1, 2, 2, CMAX, 1, CMAX - 1, 2));

        // Full rate on both sides; the receiver holds off for a long stretch early on.
        hold_at = requests_sent + 40;
        run_phase(PHASE_ITEMS);
        send_pct = 46;
        recv_pct = 0;
        run_phase(PHASE_ITEMS);
        // Pause the sender until the block has returned everything.
        wait_drained();
        send_pct = 0;
        recv_pct = 46;
        run_phase(PHASE_ITEMS);
        send_pct = 16;
        recv_pct = 16;
        run_phase(PHASE_ITEMS);

        recv_pct = 0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.crossings_due.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Result side: grade each accepted result, then pick ready for the next edge.
    initial begin : result_side
        int        hold_left;
        bit        held;
        crossing_t got;
        hold_left = 0;
        held      = 1'b0;
        res.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (res.valid && res.ready) begin
                got.x         = res.cross_x;
                got.y         = res.cross_y;
                got.parallel  = res.parallel;
                got.saturated = res.saturated;
                board.check_result(got);
            end
            if (!held && hold_at >= 0 && requests_sent >= hold_at) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res.ready <= 1'b0;
            end else begin
                res.ready <= ($urandom_range(99) >= recv_pct);
            end
        end
    end

    // Stop a hung run long after the slowest correct one would have ended.
    initial begin : watchdog
        #(12 * 400000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
